FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/fsk_pkg.sv
package fsk_pkg;

  // Sizing of the phase accumulator and the sine table.
  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_AMP_BITS   = 16;

  localparam int unsigned TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int unsigned ROM_ADDR_W = SINE_TABLE_BITS + 1;
  localparam int unsigned PHASE_IDX_W = SINE_TABLE_BITS + 2;
  localparam int unsigned SINE_AMP   = (1 << (SINE_AMP_BITS - 1)) - 1;

  localparam logic [63:0] QONE        = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP64       = 64'(SINE_AMP);
  localparam logic [63:0] TWO_AMP64   = 64'(2 * SINE_AMP);

  // Transaction opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Sample formats.
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S8  = 2'd1;
  localparam logic [1:0] FMT_U16 = 2'd2;
  localparam logic [1:0] FMT_S16 = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE0_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE1_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN      = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        sample_valid;
    logic        last_of_byte;
    logic        byte_accepted;
  } out_t;

  // One table entry: every encoding of +m and -m that differs by more than a sign.
  typedef struct packed {
    logic [7:0]  u8_pos;
    logic [7:0]  u8_neg;
    logic [7:0]  s8;
    logic [15:0] u16_pos;
    logic [15:0] u16_neg;
    logic [15:0] s16;
  } rom_word_t;

  // Transaction held between the table read and the output register.
  typedef struct packed {
    rom_word_t rom;
    logic      neg;
    logic      sample_valid;
    logic      last_of_byte;
    logic      byte_accepted;
  } stage_t;

  // Quarter-wave sine magnitude for entry k, already encoded for all formats.
  // Evaluated at elaboration only; the series uses truncating Q30 arithmetic.
  function automatic rom_word_t rom_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] m;
    rom_word_t   w;
    x  = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    t  = QONE;
    d  = ((x2 * t) >> 30) / 156;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    d  = ((x2 * t) >> 30) / 110;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    d  = ((x2 * t) >> 30) / 72;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    d  = ((x2 * t) >> 30) / 42;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    d  = ((x2 * t) >> 30) / 20;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    d  = ((x2 * t) >> 30) / 6;
    t  = (d > QONE) ? 64'd0 : QONE - d;
    s  = (x * t) >> 30;
    m  = (s * AMP64 + (QONE >> 1)) >> 30;
    if (m > AMP64) begin
      m = AMP64;
    end
    w.u8_pos  = 8'(((m + AMP64) * 64'd255) / TWO_AMP64);
    w.u8_neg  = 8'(((AMP64 - m) * 64'd255) / TWO_AMP64);
    w.s8      = 8'((m * 64'd127) / AMP64);
    w.u16_pos = 16'(((m + AMP64) * 64'd65535) / TWO_AMP64);
    w.u16_neg = 16'(((AMP64 - m) * 64'd65535) / TWO_AMP64);
    w.s16     = 16'((m * 64'd32767) / AMP64);
    return w;
  endfunction

endpackage

FILE: sv/fsk_tone_modulator.sv
// Binary FSK tone modulator.
// Input channel (in_valid, in_stall, in_data): each transaction is a push that
// loads one byte, or a tick that asks for one audio sample. A push made while a
// byte is still being sent is refused and reported with byte_accepted low.
// Output channel (out_valid, out_stall, out_data): exactly one result per input
// transaction, in order. Ticks while a byte is loaded give a sine sample at the
// tone of the current bit (LSB first); each bit lasts samples_per_bit ticks and
// restarts the phase at zero. Idle ticks and pushes give a zero sample.
// A transaction accepted at one edge has its registered sine table read (1025
// entries) done at that edge; its format selection is loaded into the output
// register when the table stage moves on, which a receiver stall can delay.
// One transaction is accepted every cycle while the output flows.
// When the receiver stalls, the output register and the table stage hold their
// transactions and in_stall rises once both are full; nothing is dropped.
// Configuration writes (cfg_we, cfg_index, cfg_data) act on the next cycle.
// Reset (rst_n low, synchronous) empties the pipeline, drops any loaded byte and
// restores the default tones, 441 samples per bit, unsigned 8-bit little-endian.
`include "assert_macros.svh"

module fsk_tone_modulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fsk_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fsk_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [fsk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsk_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned PB = fsk_pkg::PHASE_BITS;
  localparam int unsigned TB = fsk_pkg::SINE_TABLE_BITS;
  localparam int unsigned AW = fsk_pkg::ROM_ADDR_W;
  localparam int unsigned IW = fsk_pkg::PHASE_IDX_W;

  // Configuration registers.
  logic [31:0] tone0_step_r;
  logic [31:0] tone1_step_r;
  logic [15:0] samples_per_bit_r;
  logic [1:0]  sample_format_r;
  logic        big_endian_r;

  // Modulator state.
  logic [7:0]    shift_byte_r, shift_byte_nxt;
  logic [2:0]    bit_index_r, bit_index_nxt;
  logic [15:0]   sample_index_r, sample_index_nxt;
  logic [PB-1:0] phase_acc_r, phase_acc_nxt;
  logic          busy_r, busy_nxt;

  // Pipeline registers.
  logic            s1_valid_r;
  fsk_pkg::stage_t s1_r;
  fsk_pkg::stage_t s1_nxt;
  logic            out_valid_r;
  fsk_pkg::out_t   out_r;
  fsk_pkg::out_t   out_nxt;

  logic          in_accept;
  logic          out_free;
  logic          s1_move;
  logic          cur_bit;
  logic [PB-1:0] step;
  logic [15:0]   spb_eff;
  logic          bit_end;
  logic [IW-1:0] phase_idx;
  logic [AW-1:0] rom_addr;
  logic [15:0]   enc;
  logic          push_busy;

  fsk_pkg::rom_word_t rom_w [0:fsk_pkg::TAB_N];

  // Sine table contents, fixed at elaboration.
  for (genvar k = 0; k <= fsk_pkg::TAB_N; k++) begin : g_rom
    localparam fsk_pkg::rom_word_t ENTRY = fsk_pkg::rom_entry(k);
    assign rom_w[k] = ENTRY;
  end

  // Handshake: the output register frees when taken, the table stage when it moves on.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign push_busy = in_accept && (in_data.op == fsk_pkg::OP_PUSH) && busy_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone0_step_r      <= 32'd136348168;
      tone1_step_r      <= 32'd204522252;
      samples_per_bit_r <= 16'd441;
      sample_format_r   <= fsk_pkg::FMT_U8;
      big_endian_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsk_pkg::CFG_TONE0_STEP:      tone0_step_r      <= cfg_data;
        fsk_pkg::CFG_TONE1_STEP:      tone1_step_r      <= cfg_data;
        fsk_pkg::CFG_SAMPLES_PER_BIT: samples_per_bit_r <= cfg_data[15:0];
        fsk_pkg::CFG_SAMPLE_FORMAT:   sample_format_r   <= cfg_data[1:0];
        fsk_pkg::CFG_BIG_ENDIAN:      big_endian_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Current bit, its tone and the table address for the present phase.
  assign cur_bit   = shift_byte_r[bit_index_r];
  assign step      = cur_bit ? tone1_step_r[PB-1:0] : tone0_step_r[PB-1:0];
  assign spb_eff   = (samples_per_bit_r == 16'd0) ? 16'd1 : samples_per_bit_r;
  assign bit_end   = ({1'b0, sample_index_r} + 17'd1) >= {1'b0, spb_eff};
  assign phase_idx = phase_acc_r[PB-1 -: IW];
  assign rom_addr  = phase_idx[TB] ? (AW'(fsk_pkg::TAB_N) - {1'b0, phase_idx[TB-1:0]})
                                   : {1'b0, phase_idx[TB-1:0]};

  // Next modulator state and the flags of the accepted transaction.
  always_comb begin
    shift_byte_nxt   = shift_byte_r;
    bit_index_nxt    = bit_index_r;
    sample_index_nxt = sample_index_r;
    phase_acc_nxt    = phase_acc_r;
    busy_nxt         = busy_r;
    s1_nxt.rom           = rom_w[rom_addr];
    s1_nxt.neg           = phase_idx[TB+1];
    s1_nxt.sample_valid  = 1'b0;
    s1_nxt.last_of_byte  = 1'b0;
    s1_nxt.byte_accepted = 1'b0;
    if (in_accept) begin
      if (in_data.op == fsk_pkg::OP_PUSH) begin
        if (!busy_r) begin
          shift_byte_nxt       = in_data.data_byte;
          bit_index_nxt        = 3'd0;
          sample_index_nxt     = 16'd0;
          phase_acc_nxt        = '0;
          busy_nxt             = 1'b1;
          s1_nxt.byte_accepted = 1'b1;
        end
      end else if (busy_r) begin
        s1_nxt.sample_valid = 1'b1;
        if (bit_end) begin
          sample_index_nxt = 16'd0;
          phase_acc_nxt    = '0;
          if (bit_index_r == 3'd7) begin
            busy_nxt            = 1'b0;
            bit_index_nxt       = 3'd0;
            s1_nxt.last_of_byte = 1'b1;
          end else begin
            bit_index_nxt = bit_index_r + 3'd1;
          end
        end else begin
          sample_index_nxt = sample_index_r + 16'd1;
          phase_acc_nxt    = phase_acc_r + step;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_byte_r   <= 8'd0;
      bit_index_r    <= 3'd0;
      sample_index_r <= 16'd0;
      phase_acc_r    <= '0;
      busy_r         <= 1'b0;
    end else begin
      shift_byte_r   <= shift_byte_nxt;
      bit_index_r    <= bit_index_nxt;
      sample_index_r <= sample_index_nxt;
      phase_acc_r    <= phase_acc_nxt;
      busy_r         <= busy_nxt;
    end
  end

  // Table stage: registered read of the sine table with the transaction flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Format selection, sign and byte order.
  always_comb begin
    case (sample_format_r)
      fsk_pkg::FMT_U8:  enc = {8'd0, s1_r.neg ? s1_r.rom.u8_neg : s1_r.rom.u8_pos};
      fsk_pkg::FMT_S8:  enc = {8'd0, s1_r.neg ? 8'(-s1_r.rom.s8) : s1_r.rom.s8};
      fsk_pkg::FMT_U16: enc = s1_r.neg ? s1_r.rom.u16_neg : s1_r.rom.u16_pos;
      fsk_pkg::FMT_S16: enc = s1_r.neg ? 16'(-s1_r.rom.s16) : s1_r.rom.s16;
      default:          enc = 16'd0;
    endcase
    if (big_endian_r && sample_format_r[1]) begin
      enc = {enc[7:0], enc[15:8]};
    end
    out_nxt.sample        = s1_r.sample_valid ? enc : 16'd0;
    out_nxt.sample_valid  = s1_r.sample_valid;
    out_nxt.last_of_byte  = s1_r.last_of_byte;
    out_nxt.byte_accepted = s1_r.byte_accepted;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  // A result never reports both a loaded byte and a sample.
  `ASSERT_NEVER(a_one_kind, out_valid_r && out_r.sample_valid && out_r.byte_accepted, "both set")
  // The byte ends exactly when its final sample enters the table stage.
  `ASSERT_PROP(a_busy_fall, $fell(busy_r) |-> (s1_valid_r && s1_r.last_of_byte), "no last sample")
  // The last sample of a byte is always a real sample.
  `ASSERT_PROP(a_last_valid, (s1_valid_r && s1_r.last_of_byte) |-> s1_r.sample_valid, "no sample")
  // A push that arrives while a byte is in flight is refused.
  `ASSERT_PROP(a_push_refused, push_busy |=> !s1_r.byte_accepted, "push accepted while busy")

endmodule

FILE: sim/fsk_tone_modulator_tb.sv
`timescale 1ns / 1ps

module fsk_tone_modulator_tb;
  import fsk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 112;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Scoreboard: tracks the modulator state and the queue of predicted samples.
  class tone_scoreboard;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE          = 64'd1 << 30;

    int sine_mag [TAB_N + 1];
    out_t pending_samples [$];

    logic [31:0]           tone0;
    logic [31:0]           tone1;
    logic [15:0]           spb;
    logic [1:0]            fmt;
    bit                    swap_bytes;

    logic [7:0]            shift_byte;
    int unsigned           bit_index;
    int unsigned           sample_index;
    logic [PHASE_BITS-1:0] phase;
    bit                    busy;

    int mismatches;
    int checked;
    int tone_samples;
    int bytes_done;
    int refused;

    function new();
      build_table();
      tone0        = 32'd136348168;
      tone1        = 32'd204522252;
      spb          = 16'd441;
      fmt          = FMT_U8;
      swap_bytes   = 1'b0;
      shift_byte   = '0;
      bit_index    = 0;
      sample_index = 0;
      phase        = '0;
      busy         = 1'b0;
    endfunction

    // Quarter-wave magnitudes from a truncating Q30 Taylor series.
    function void build_table();
      longint unsigned divisors [6];
      longint unsigned x, x2, t, d, s, m;
      longint unsigned amp;
      amp = longint'(SINE_AMP);
      divisors = '{156, 110, 72, 42, 20, 6};
      for (int k = 0; k <= TAB_N; k++) begin
        x  = (QUARTER_TURN_Q30 * longint'(k)) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
          d = ((x2 * t) >> 30) / divisors[i];
          t = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
        end
        s = (x * t) >> 30;
        m = (s * amp + (Q30_ONE >> 1)) >> 30;
        if (m > amp) begin
          m = amp;
        end
        sine_mag[k] = int'(m);
      end
    endfunction

    // Signed sine value at a phase, using the top index bits and quadrant mirroring.
    function longint sine_at(logic [PHASE_BITS-1:0] ph);
      logic [PHASE_IDX_W-1:0]     idx;
      logic [1:0]                 quad;
      int unsigned                off;
      longint                     mag;
      idx  = PHASE_IDX_W'(ph >> (PHASE_BITS - SINE_TABLE_BITS - 2));
      quad = idx[SINE_TABLE_BITS +: 2];
      off  = idx[SINE_TABLE_BITS-1:0];
      mag  = quad[0] ? sine_mag[TAB_N - off] : sine_mag[off];
      return quad[1] ? -mag : mag;
    endfunction

    // Encoding with truncating scale; 16-bit words may be byte-swapped.
    function logic [15:0] encode(longint v);
      longint      amp;
      longint      q;
      logic [15:0] word;
      amp = longint'(SINE_AMP);
      case (fmt)
        FMT_U8: begin
          q = ((v + amp) * 255) / (2 * amp);
          word = {8'd0, q[7:0]};
        end
        FMT_S8: begin
          q = (v * 127) / amp;
          word = {8'd0, q[7:0]};
        end
        FMT_U16: begin
          q = ((v + amp) * 65535) / (2 * amp);
          word = q[15:0];
        end
        default: begin
          q = (v * 32767) / amp;
          word = q[15:0];
        end
      endcase
      if (swap_bytes && fmt[1]) begin
        word = {word[7:0], word[15:8]};
      end
      return word;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TONE0_STEP:      tone0 = data;
        CFG_TONE1_STEP:      tone1 = data;
        CFG_SAMPLES_PER_BIT: spb = data[15:0];
        CFG_SAMPLE_FORMAT:   fmt = data[1:0];
        CFG_BIG_ENDIAN:      swap_bytes = data[0];
        default: ;
      endcase
    endfunction

    // Advances the modulator by one transaction and returns its result.
    function out_t advance_tone(in_t item);
      out_t                  res;
      logic [PHASE_BITS-1:0] step;
      int unsigned           span;
      res = '0;
      if (item.op == OP_PUSH) begin
        if (!busy) begin
          shift_byte = item.data_byte;
          bit_index = 0;
          sample_index = 0;
          phase = '0;
          busy = 1'b1;
          res.byte_accepted = 1'b1;
        end
        return res;
      end
      if (busy) begin
        step = shift_byte[bit_index] ? tone1[PHASE_BITS-1:0] : tone0[PHASE_BITS-1:0];
        span = (spb == 16'd0) ? 1 : spb;
        res.sample = encode(sine_at(phase));
        res.sample_valid = 1'b1;
        phase = phase + step;
        if (sample_index + 1 >= span) begin
          // Bit boundary: the phase restarts at zero for the next bit.
          sample_index = 0;
          phase = '0;
          if (bit_index >= 7) begin
            busy = 1'b0;
            bit_index = 0;
            res.last_of_byte = 1'b1;
          end else begin
            bit_index++;
          end
        end else begin
          sample_index = (sample_index + 1) & 32'hFFFF;
        end
      end
      return res;
    endfunction

    function void accept_item(in_t item);
      pending_samples = {pending_samples, advance_tone(item)};
    endfunction

    function void check_sample(out_t got);
      out_t want;
      if (pending_samples.size() == 0) begin
        $error("result with no transaction pending: sample %h", got.sample);
        mismatches++;
        return;
      end
      want = pending_samples.pop_front();
      checked++;
      if (want.sample_valid) tone_samples++;
      if (want.last_of_byte) bytes_done++;
      if (got.sample !== want.sample) begin
        $error("sample: expected %h, actual %h", want.sample, got.sample);
        mismatches++;
      end
      if (got.sample_valid !== want.sample_valid) begin
        $error("sample_valid: expected %b, actual %b", want.sample_valid, got.sample_valid);
        mismatches++;
      end
      if (got.last_of_byte !== want.last_of_byte) begin
        $error("last_of_byte: expected %b, actual %b", want.last_of_byte, got.last_of_byte);
        mismatches++;
      end
      if (got.byte_accepted !== want.byte_accepted) begin
        $error("byte_accepted: expected %b, actual %b",
               want.byte_accepted, got.byte_accepted);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tone_scoreboard tones = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_armed;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned sent;

  fsk_tone_modulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fsk_tone_modulator: mismatch");
    $finish;
  end

  // Result side: checks each accepted transaction, then picks the next stall.
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        tones.check_sample(out_data);
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_t item_of(logic op, logic [7:0] data_byte);
    in_t item;
    item.op = op;
    item.data_byte = data_byte;
    return item;
  endfunction

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic send_item(input in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    tones.accept_item(item);
    sent++;
    if (item.op == OP_PUSH && tones.pending_samples[$].byte_accepted == 1'b0) begin
      tones.refused++;
    end
  endtask

  // Stops offering and waits until every predicted sample has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tones.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    tones.set_reg(idx, data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes every register; it is called once all results are drained, and a byte may still be loaded.
  task automatic program_regs(input logic [31:0] t0, input logic [31:0] t1,
                              input logic [15:0] span, input logic [1:0] form,
                              input logic swap);
    write_reg(CFG_TONE0_STEP, t0);
    write_reg(CFG_TONE1_STEP, t1);
    write_reg(CFG_SAMPLES_PER_BIT, CFG_DATA_W'(span));
    write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(form));
    write_reg(CFG_BIG_ENDIAN, CFG_DATA_W'(swap));
    cfg_we <= 1'b0;
  endtask

  // Stimulus and end of run.
  initial begin
    logic [31:0] t0, t1;
    logic [15:0] span;
    int unsigned mode;
    in_t         item;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_armed = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, load, refused push, a few samples at reset settings.
    send_item(item_of(OP_TICK, 8'h3C));
    send_item(item_of(OP_PUSH, 8'hA5));
    send_item(item_of(OP_PUSH, 8'h00));
    repeat (3) send_item(item_of(OP_TICK, 8'hFF));
    drain();

    // Samples per bit lowered below the running count: the bit ends at once.
    program_regs(32'd136348168, 32'd204522252, 16'd1, FMT_U8, 1'b0);
    repeat (9) send_item(item_of(OP_TICK, 8'h00));
    drain();

    // Extreme tones, zero samples per bit, swapped signed 16-bit words.
    program_regs(32'hFFFF_FFFF, 32'h4000_0000, 16'd0, FMT_S16, 1'b1);
    send_item(item_of(OP_PUSH, 8'hFF));
    repeat (8) send_item(item_of(OP_TICK, 8'h5A));
    send_item(item_of(OP_PUSH, 8'h00));
    drain();

    // Random phases: every format and byte order, several idle patterns.
    for (int p = 0; p < PHASES; p++) begin
      t0 = (p == 0) ? 32'd0 : $urandom;
      t1 = (p == 1) ? 32'hFFFF_FFFF : $urandom;
      if (p == 5) begin
        span = 16'hFFFF;
      end else if (p == 6) begin
        span = 16'd0;
      end else begin
        span = 16'($urandom_range(1, 6));
      end
      program_regs(t0, t1, span, 2'(p >> 1), p[0]);
      mode = (p + p / 4) % 4;
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // Long receiver hold-off while items keep coming, so the input backs up.
      if (p == 0) begin
        hold_armed = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (tones.busy) begin
          item.op = ($urandom_range(99) < 88) ? OP_TICK : OP_PUSH;
        end else begin
          item.op = ($urandom_range(99) < 80) ? OP_PUSH : OP_TICK;
        end
        item.data_byte = 8'($urandom);
        send_item(item);
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d transactions over %0d random settings plus directed cases.",
             sent, PHASES);
    $display("Checked %0d results: %0d tone samples, %0d bytes sent, %0d pushes refused.",
             tones.checked, tones.tone_samples, tones.bytes_done, tones.refused);
    if (tones.mismatches == 0 && tones.pending() == 0) begin
      $display("fsk_tone_modulator: match");
    end else begin
      $display("fsk_tone_modulator: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/fsk_pkg.sv
sv/fsk_tone_modulator.sv
sim/fsk_tone_modulator_tb.sv
